[rtl/vrrb_pkg.sv]
// ----------------------------------------------------------------------------
// vrrb_pkg
// Shared types and codes of the variable-length record ring buffer.
// ----------------------------------------------------------------------------
package vrrb_pkg;

  localparam int UnitBytes = 16;
  localparam int UnitShift = 4;
  localparam int EntryW    = 41;

  localparam logic FuncAppend = 1'b0;
  localparam logic FuncTake   = 1'b1;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusTooLarge = 2'd2;
  localparam logic [1:0] StatusEmpty    = 2'd3;

  typedef struct packed {
    logic        wrap;
    logic [15:0] conn;
    logic        flag;
    logic [3:0]  op;
    logic [2:0]  kind;
    logic [15:0] len;
  } hdr_t;

endpackage

[rtl/vrrb_ram.sv]
// ----------------------------------------------------------------------------
// vrrb_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module vrrb_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/variable_record_ring_buffer_top.sv]
// ----------------------------------------------------------------------------
// variable_record_ring_buffer_top
// Ring of variable-length records kept in 16-byte units, with wrap markers.
// ----------------------------------------------------------------------------
// Usage:
//   Drive func, the header fields and start; a command transaction is taken
//   at a rising edge with start high and busy low. func 0 appends a record,
//   func 1 takes the oldest one.
//   Each command yields one result, shown for one cycle with done_o high.
//   States from the accepting edge to the result cycle:
//     too large or empty take      result from idle, no further state
//     append, take                 SAppend or STake
//     append that wraps            SAppend, SWrapHdr
//     take that skips a marker     STake, STake2; STake alone when the ring is then empty
//   The single header RAM port sets these states: a take reads it, and
//   reads again after a marker; a wrapping append writes marker and header.
//   A new command can be taken in the result cycle; none is taken while
//   busy is high.
//   Reset empties the ring and clears the pending resume; the header RAM is
//   not cleared and needs no clearing pass.
//   The receiver cannot stall; each result must be taken when shown.
// ----------------------------------------------------------------------------
module variable_record_ring_buffer_top #(
  parameter int RING_UNITS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [15:0] payload_length_i,
  input  logic [2:0]  record_type_i,
  input  logic [3:0]  op_code_i,
  input  logic        heap_flag_i,
  input  logic [15:0] conn_tag_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [13:0] payload_offset_o,
  output logic [15:0] rec_length_o,
  output logic [2:0]  rec_type_o,
  output logic [3:0]  rec_op_code_o,
  output logic        rec_heap_flag_o,
  output logic [15:0] rec_conn_tag_o,
  output logic        resume_request_o
);

  localparam int AddrW = $clog2(RING_UNITS);
  localparam int PosW  = AddrW + vrrb_pkg::UnitShift;
  localparam logic [31:0] RingBytes = 32'(RING_UNITS) << vrrb_pkg::UnitShift;
  localparam logic [31:0] HalfBytes = RingBytes >> 1;
  localparam logic [31:0] UnitB32   = 32'(vrrb_pkg::UnitBytes);

  localparam logic [2:0] SIdle    = 3'd0;
  localparam logic [2:0] SAppend  = 3'd1;
  localparam logic [2:0] SWrapHdr = 3'd2;
  localparam logic [2:0] STake    = 3'd3;
  localparam logic [2:0] STake2   = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [31:0] wi_q, wi_d, ri_q, ri_d;
  logic        resume_q, resume_d;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [16:0]      need_q, need_d;
  logic             wrap_q, wrap_d;
  logic [31:0]      total_q, total_d, room_q, room_d;
  vrrb_pkg::hdr_t   hdr_q, hdr_d;

  logic             res_valid_d;
  logic [1:0]       res_status_d;
  logic [13:0]      res_offset_d;
  vrrb_pkg::hdr_t   res_hdr_d;
  logic             res_resume_d;

  logic             done_q;
  logic [1:0]       status_q;
  logic [13:0]      offset_q;
  vrrb_pkg::hdr_t   rec_q;
  logic             rec_resume_q;

  logic             ram_en, ram_we;
  logic [AddrW-1:0] ram_addr;
  vrrb_pkg::hdr_t   ram_wdata, ram_rdata;

  logic             accept;
  logic [16:0]      need_in;
  logic [PosW-1:0]  wpos, rpos;
  logic [31:0]      end_pos, used, skip_ri;
  logic [31:0]      rd_off;
  logic [31:0]      take_len;

  assign accept = start && !busy;
  assign busy   = (state_q != SIdle);

  assign need_in = ((17'(payload_length_i) + 17'd15) & ~17'd15) + 17'(vrrb_pkg::UnitBytes);
  assign wpos    = wi_q[PosW-1:0];
  assign rpos    = ri_q[PosW-1:0];
  assign end_pos = 32'(wpos) + 32'(need_in);
  assign used    = wi_q - ri_q;
  assign skip_ri = ri_q + RingBytes - 32'(pos_q);
  assign rd_off  = 32'(pos_q) + UnitB32;

  vrrb_ram #(
    .WIDTH (vrrb_pkg::EntryW),
    .DEPTH (RING_UNITS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    wi_d         = wi_q;
    ri_d         = ri_q;
    resume_d     = resume_q;
    pos_d        = pos_q;
    need_d       = need_q;
    wrap_d       = wrap_q;
    total_d      = total_q;
    room_d       = room_q;
    hdr_d        = hdr_q;
    res_valid_d  = 1'b0;
    res_status_d = vrrb_pkg::StatusOk;
    res_offset_d = '0;
    res_hdr_d    = '0;
    res_resume_d = 1'b0;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = pos_q[PosW-1:vrrb_pkg::UnitShift];
    ram_wdata    = hdr_q;
    take_len     = ((32'(ram_rdata.len) + 32'd15) & ~32'd15) + UnitB32;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          if (func_i == vrrb_pkg::FuncAppend) begin
            hdr_d.wrap = 1'b0;
            hdr_d.conn = conn_tag_i;
            hdr_d.flag = heap_flag_i;
            hdr_d.op   = op_code_i;
            hdr_d.kind = record_type_i;
            hdr_d.len  = payload_length_i;
            need_d     = need_in;
            pos_d      = wpos;
            wrap_d     = end_pos > RingBytes;
            total_d    = (end_pos > RingBytes) ? RingBytes - 32'(wpos) + 32'(need_in)
                                               : 32'(need_in);
            room_d     = (used > RingBytes) ? 32'd0 : RingBytes - used;
            if (32'(need_in) > HalfBytes) begin
              res_valid_d  = 1'b1;
              res_status_d = vrrb_pkg::StatusTooLarge;
            end else begin
              state_d = SAppend;
            end
          end else begin
            if (ri_q == wi_q) begin
              res_valid_d  = 1'b1;
              res_status_d = vrrb_pkg::StatusEmpty;
            end else begin
              ram_en   = 1'b1;
              ram_addr = rpos[PosW-1:vrrb_pkg::UnitShift];
              pos_d    = rpos;
              state_d  = STake;
            end
          end
        end
      end
      SAppend: begin
        if (room_q < total_q) begin
          resume_d     = 1'b1;
          res_valid_d  = 1'b1;
          res_status_d = vrrb_pkg::StatusFull;
          state_d      = SIdle;
        end else if (wrap_q) begin
          ram_en    = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = '0;
          ram_wdata.wrap = 1'b1;
          wi_d      = wi_q + RingBytes - 32'(pos_q);
          pos_d     = '0;
          state_d   = SWrapHdr;
        end else begin
          ram_en       = 1'b1;
          ram_we       = 1'b1;
          wi_d         = wi_q + 32'(need_q);
          res_valid_d  = 1'b1;
          res_offset_d = rd_off[13:0];
          state_d      = SIdle;
        end
      end
      SWrapHdr: begin
        ram_en       = 1'b1;
        ram_we       = 1'b1;
        wi_d         = wi_q + 32'(need_q);
        res_valid_d  = 1'b1;
        res_offset_d = rd_off[13:0];
        state_d      = SIdle;
      end
      STake: begin
        if (ram_rdata.wrap) begin
          ri_d = skip_ri;
          if (skip_ri == wi_q) begin
            res_valid_d  = 1'b1;
            res_status_d = vrrb_pkg::StatusEmpty;
            state_d      = SIdle;
          end else begin
            ram_en   = 1'b1;
            ram_addr = '0;
            pos_d    = '0;
            state_d  = STake2;
          end
        end else begin
          ri_d           = ri_q + take_len;
          res_valid_d    = 1'b1;
          res_offset_d   = rd_off[13:0];
          res_hdr_d      = ram_rdata;
          res_hdr_d.wrap = 1'b0;
          res_resume_d   = resume_q;
          resume_d       = 1'b0;
          state_d        = SIdle;
        end
      end
      STake2: begin
        ri_d           = ri_q + take_len;
        res_valid_d    = 1'b1;
        res_offset_d   = rd_off[13:0];
        res_hdr_d      = ram_rdata;
        res_hdr_d.wrap = 1'b0;
        res_resume_d   = resume_q;
        resume_d       = 1'b0;
        state_d        = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      wi_q     <= '0;
      ri_q     <= '0;
      resume_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      wi_q     <= wi_d;
      ri_q     <= ri_d;
      resume_q <= resume_d;
      done_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    need_q  <= need_d;
    wrap_q  <= wrap_d;
    total_q <= total_d;
    room_q  <= room_d;
    hdr_q   <= hdr_d;
    if (res_valid_d) begin
      status_q     <= res_status_d;
      offset_q     <= res_offset_d;
      rec_q        <= res_hdr_d;
      rec_resume_q <= res_resume_d;
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign payload_offset_o = offset_q;
  assign rec_length_o     = rec_q.len;
  assign rec_type_o       = rec_q.kind;
  assign rec_op_code_o    = rec_q.op;
  assign rec_heap_flag_o  = rec_q.flag;
  assign rec_conn_tag_o   = rec_q.conn;
  assign resume_request_o = rec_resume_q;

endmodule

[rtl/vrrb_checker.sv]
// ----------------------------------------------------------------------------
// vrrb_checker
// Port-level checks of the record ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module vrrb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        func_i,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [13:0] payload_offset_o,
  input logic [15:0] rec_length_o,
  input logic [2:0]  rec_type_o,
  input logic [3:0]  rec_op_code_o,
  input logic        rec_heap_flag_o,
  input logic [15:0] rec_conn_tag_o,
  input logic        resume_request_o
);

  logic func_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q <= vrrb_pkg::FuncAppend;
    end else if (start && !busy) begin
      func_q <= func_i;
    end
  end

  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != vrrb_pkg::StatusOk) |->
      payload_offset_o == 14'd0 && rec_length_o == 16'd0 && rec_conn_tag_o == 16'd0 &&
      !resume_request_o)
    else $error("failed transaction carries nonzero fields");

  a_append_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (func_q == vrrb_pkg::FuncAppend) |->
      rec_length_o == 16'd0 && rec_type_o == 3'd0 && rec_op_code_o == 4'd0 &&
      !rec_heap_flag_o && rec_conn_tag_o == 16'd0 && !resume_request_o &&
      status_o != vrrb_pkg::StatusEmpty)
    else $error("append transaction returns record fields");

  a_offset_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> payload_offset_o[3:0] == 4'd0)
    else $error("payload offset not unit aligned");

  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy) || $past(busy))
    else $error("result without a command transaction");

endmodule

bind variable_record_ring_buffer_top vrrb_checker u_vrrb_checker (.*);
